FILE: design/sgb_pkg.sv
// Shared types and constants for the segment gap bridger.
package sgb_pkg;

   localparam int COORD_BITS = 12;
   localparam int LIMIT_BITS = 16;
   localparam int DIST_BITS = 2 * COORD_BITS + 1;
   localparam int MAX_SEGMENTS_DEFAULT = 64;
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 16'd1200;
   localparam logic [DIST_BITS-1:0] GAP_BOUND = DIST_BITS'(50000);

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [DIST_BITS-1:0] dist_type;

   typedef struct packed {
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
      logic      new_set;
   } req_type;

   typedef struct packed {
      coord_type from_x;
      coord_type from_y;
      coord_type to_x;
      coord_type to_y;
      logic      last;
   } rsp_type;

   typedef struct packed {
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
   } seg_type;

   typedef struct packed {
      logic    valid;
      logic    hit;
      rsp_type bridge;
   } cand_type;

   localparam int SEG_BITS = $bits(seg_type);

endpackage

FILE: design/segment_gap_bridger.sv
// Top level of the segment gap bridger: table sequencer, bridge emitter and limit register.
//
//   Channel   Ports                         Handshake
//   request   start, busy, req_data         beat taken when start is high and busy is low
//   response  rsp_valid, rsp_data           one beat per cycle of rsp_valid, never stalled
//   csr       csr_write_en, csr_write_data  written when csr_write_en is high
//
// An item with N stored segments keeps busy high while the table RAM is read one entry
// per cycle, the four-stage read and distance pipeline drains, and a final DRAIN step
// releases the held bridge.
// The last bridge is held back one beat so that it can carry last; it appears on the
// response ports in the same cycle that busy falls.
// Reset empties the table and restores the limit; the table RAM itself is not cleared.
// The response side cannot stall, so at most one bridge leaves per cycle.
module segment_gap_bridger #(
   parameter int MAX_SEGMENTS = sgb_pkg::MAX_SEGMENTS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  sgb_pkg::req_type               req_data,
   output logic                           busy,
   output logic                           rsp_valid,
   output sgb_pkg::rsp_type               rsp_data,
   input  logic                           csr_write_en,
   input  logic [sgb_pkg::LIMIT_BITS-1:0] csr_write_data
);
   import sgb_pkg::*;

   localparam int IdxBits = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int CntBits = $clog2(MAX_SEGMENTS + 1);
   localparam logic [CntBits-1:0] MaxCount = CntBits'(MAX_SEGMENTS);
   localparam logic [CntBits-1:0] MaxBridges = CntBits'(MAX_SEGMENTS - 1);
   localparam logic [2:0] DrainLast = 3'd4;

   typedef enum logic [1:0] {
      IDLE,
      SCAN,
      DRAIN
   } state_type;

   state_type            state_ff, state_in;
   logic [CntBits-1:0]   count_ff, count_in;
   logic [CntBits-1:0]   total_ff, total_in;
   logic [CntBits-1:0]   nbr_ff, nbr_in;
   logic [IdxBits-1:0]   rd_idx_ff, rd_idx_in;
   logic [2:0]           drain_ff, drain_in;
   logic                 rd_vld_ff;
   logic                 pend_vld_ff, pend_vld_in;
   rsp_type              pend_ff, pend_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;
   logic [LIMIT_BITS-1:0] limit_ff, limit_in;
   seg_type              seg_ff, seg_in;

   logic                 accept;
   logic [CntBits-1:0]   cnt_eff;
   logic                 room;
   logic                 rd_en;
   logic                 take;
   seg_type              req_seg;
   seg_type              old_seg;
   cand_type             cand;

   assign req_seg.start_x = req_data.start_x;
   assign req_seg.start_y = req_data.start_y;
   assign req_seg.end_x = req_data.end_x;
   assign req_seg.end_y = req_data.end_y;

   assign accept = start && (state_ff == IDLE);
   assign cnt_eff = req_data.new_set ? '0 : count_ff;
   assign room = cnt_eff < MaxCount;
   assign rd_en = (state_ff == SCAN);
   assign take = cand.valid && cand.hit && (nbr_ff < MaxBridges);

   sgb_ram #(
      .WIDTH(SEG_BITS),
      .DEPTH(MAX_SEGMENTS)
   ) u_table (
      .clock  (clock),
      .wr_en  (accept && room),
      .wr_addr(cnt_eff[IdxBits-1:0]),
      .wr_data(req_seg),
      .rd_en  (rd_en),
      .rd_addr(rd_idx_ff),
      .rd_data(old_seg)
   );

   sgb_match u_match (
      .clock    (clock),
      .reset    (reset),
      .old_valid(rd_vld_ff),
      .old_seg  (old_seg),
      .new_seg  (seg_ff),
      .limit    (limit_ff),
      .cand     (cand)
   );

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      total_in = total_ff;
      nbr_in = nbr_ff;
      rd_idx_in = rd_idx_ff;
      drain_in = drain_ff;
      pend_vld_in = pend_vld_ff;
      pend_in = pend_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in = pend_ff;
      limit_in = csr_write_en ? csr_write_data : limit_ff;
      seg_in = seg_ff;

      unique case (state_ff)
         IDLE: begin
            if (accept) begin
               seg_in = req_seg;
               total_in = cnt_eff;
               count_in = room ? (cnt_eff + 1'b1) : cnt_eff;
               nbr_in = '0;
               rd_idx_in = '0;
               drain_in = '0;
               pend_vld_in = 1'b0;
               state_in = (cnt_eff == '0) ? DRAIN : SCAN;
            end
         end
         SCAN: begin
            if (CntBits'(rd_idx_ff) == total_ff - 1'b1) begin
               state_in = DRAIN;
            end else begin
               rd_idx_in = rd_idx_ff + 1'b1;
            end
         end
         DRAIN: begin
            drain_in = drain_ff + 1'b1;
            if (drain_ff == DrainLast) begin
               state_in = IDLE;
               pend_vld_in = 1'b0;
               if (pend_vld_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in.last = 1'b1;
               end
            end
         end
         default: state_in = IDLE;
      endcase

      if (take) begin
         if (pend_vld_ff) begin
            rsp_valid_in = 1'b1;
            rsp_data_in = pend_ff;
            rsp_data_in.last = 1'b0;
         end
         pend_in = cand.bridge;
         pend_vld_in = 1'b1;
         nbr_in = nbr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         count_ff <= '0;
         nbr_ff <= '0;
         drain_ff <= '0;
         rd_vld_ff <= 1'b0;
         pend_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         limit_ff <= LIMIT_RESET;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         nbr_ff <= nbr_in;
         drain_ff <= drain_in;
         rd_vld_ff <= rd_en;
         pend_vld_ff <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         limit_ff <= limit_in;
      end
      total_ff <= total_in;
      rd_idx_ff <= rd_idx_in;
      pend_ff <= pend_in;
      rsp_data_ff <= rsp_data_in;
      seg_ff <= seg_in;
   end

   assign busy = (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   // The final beat of an item is never followed directly by another beat.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.last |=> !rsp_valid_ff)
      else $error("beat follows the final beat of an item");

   // A beat without last means a newer bridge is still held back.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.last |-> pend_vld_ff)
      else $error("non-final beat without a held bridge");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == IDLE |-> !pend_vld_ff)
      else $error("held bridge left behind while idle");

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= MaxCount && nbr_ff <= MaxBridges)
      else $error("table or bridge count out of range");

endmodule

FILE: design/sgb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module sgb_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/sgb_match.sv
// Distance pipeline: squares, sums and endpoint pairing choice for one stored segment.
module sgb_match (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                old_valid,
   input  sgb_pkg::seg_type                    old_seg,
   input  sgb_pkg::seg_type                    new_seg,
   input  logic [sgb_pkg::LIMIT_BITS-1:0]      limit,
   output sgb_pkg::cand_type                   cand
);
   import sgb_pkg::*;

   typedef logic [2*COORD_BITS-1:0] square_type;

   logic       p1_valid_ff;
   logic       p2_valid_ff;
   logic       p3_valid_ff;
   seg_type    p1_old_ff;
   seg_type    p2_old_ff;
   square_type sq_x_ff [4];
   square_type sq_y_ff [4];
   square_type sq_x_in [4];
   square_type sq_y_in [4];
   dist_type   dist_ff [4];
   dist_type   dist_in [4];
   cand_type   cand_ff;
   cand_type   cand_in;

   function automatic coord_type abs_diff(input coord_type a, input coord_type b);
      abs_diff = (a > b) ? (a - b) : (b - a);
   endfunction

   always_comb begin
      coord_type ox;
      coord_type oy;
      coord_type nx;
      coord_type ny;
      coord_type dx;
      coord_type dy;
      for (int k = 0; k < 4; k++) begin
         ox = k[1] ? old_seg.end_x : old_seg.start_x;
         oy = k[1] ? old_seg.end_y : old_seg.start_y;
         nx = k[0] ? new_seg.end_x : new_seg.start_x;
         ny = k[0] ? new_seg.end_y : new_seg.start_y;
         dx = abs_diff(ox, nx);
         dy = abs_diff(oy, ny);
         sq_x_in[k] = square_type'(dx) * square_type'(dx);
         sq_y_in[k] = square_type'(dy) * square_type'(dy);
      end
      for (int k = 0; k < 4; k++) begin
         dist_in[k] = dist_type'(sq_x_ff[k]) + dist_type'(sq_y_ff[k]);
      end
   end

   always_comb begin
      dist_type best;
      logic     found;
      logic     best_old;
      logic     best_new;
      best = GAP_BOUND;
      found = 1'b0;
      best_old = 1'b0;
      best_new = 1'b0;
      for (int k = 0; k < 4; k++) begin
         if (dist_ff[k] < best) begin
            best = dist_ff[k];
            found = 1'b1;
            best_old = k[1];
            best_new = k[0];
         end
      end
      cand_in.valid = p2_valid_ff;
      cand_in.hit = found && (best < dist_type'(limit));
      cand_in.bridge.from_x = best_old ? p2_old_ff.end_x : p2_old_ff.start_x;
      cand_in.bridge.from_y = best_old ? p2_old_ff.end_y : p2_old_ff.start_y;
      cand_in.bridge.to_x = best_new ? new_seg.end_x : new_seg.start_x;
      cand_in.bridge.to_y = best_new ? new_seg.end_y : new_seg.start_y;
      cand_in.bridge.last = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= old_valid;
         p2_valid_ff <= p1_valid_ff;
         p3_valid_ff <= cand_in.valid;
      end
      p1_old_ff <= old_seg;
      p2_old_ff <= p1_old_ff;
      sq_x_ff <= sq_x_in;
      sq_y_ff <= sq_y_in;
      dist_ff <= dist_in;
      cand_ff <= cand_in;
   end

   always_comb begin
      cand = cand_ff;
      cand.valid = p3_valid_ff;
   end

endmodule

FILE: tb/sgb_tb_pkg.sv
// Bridge prediction and checking for the segment gap bridger testbench.
`timescale 1ns / 100ps

package sgb_tb_pkg;
   import sgb_pkg::*;

   class bridge_tracker;
      int          max_segments;
      seg_type     seg_table [];
      int          seg_count;
      int unsigned gap_limit;
      rsp_type     expected_bridges [$];
      int          mismatches;

      function new(int depth);
         max_segments = depth;
         seg_table    = new[depth];
         seg_count    = 0;
         gap_limit    = LIMIT_RESET;
         mismatches   = 0;
      endfunction

      function int sq_gap(coord_type ax, coord_type ay, coord_type bx, coord_type by);
         int dx;
         int dy;
         dx = int'(ax) - int'(bx);
         dy = int'(ay) - int'(by);
         return dx * dx + dy * dy;
      endfunction

      function void note_segment(req_type r);
         seg_type   s;
         seg_type   old;
         rsp_type   found [$];
         rsp_type   cand;
         coord_type ox;
         coord_type oy;
         coord_type nx;
         coord_type ny;
         int        best;
         int        d;
         bit        hit;
         s.start_x = r.start_x;
         s.start_y = r.start_y;
         s.end_x   = r.end_x;
         s.end_y   = r.end_y;
         if (r.new_set) begin
            seg_count = 0;
         end
         for (int i = 0; i < seg_count; i++) begin
            old  = seg_table[i];
            best = int'(GAP_BOUND);
            hit  = 1'b0;
            cand = '0;
            for (int k = 0; k < 4; k++) begin
               ox = k[1] ? old.end_x : old.start_x;
               oy = k[1] ? old.end_y : old.start_y;
               nx = k[0] ? s.end_x : s.start_x;
               ny = k[0] ? s.end_y : s.start_y;
               d  = sq_gap(ox, oy, nx, ny);
               if (d < best) begin
                  best        = d;
                  hit         = 1'b1;
                  cand.from_x = ox;
                  cand.from_y = oy;
                  cand.to_x   = nx;
                  cand.to_y   = ny;
               end
            end
            if (hit && best < int'(gap_limit) && found.size() < max_segments - 1) begin
               found.insert(found.size(), cand);
            end
         end
         if (found.size() > 0) begin
            found[found.size() - 1].last = 1'b1;
         end
         foreach (found[j]) begin
            expected_bridges.insert(expected_bridges.size(), found[j]);
         end
         if (seg_count < max_segments) begin
            seg_table[seg_count] = s;
            seg_count++;
         end
      endfunction

      function void report(string field, int want, int got);
         $display("%0t: bridge %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatches++;
      endfunction

      function void check_bridge(rsp_type got);
         rsp_type want;
         if (expected_bridges.size() == 0) begin
            $display("%0t: unexpected bridge, expected none, actual %p", $time, got);
            mismatches++;
            return;
         end
         want = expected_bridges.pop_front();
         if (got.from_x !== want.from_x) report("from_x", want.from_x, got.from_x);
         if (got.from_y !== want.from_y) report("from_y", want.from_y, got.from_y);
         if (got.to_x !== want.to_x) report("to_x", want.to_x, got.to_x);
         if (got.to_y !== want.to_y) report("to_y", want.to_y, got.to_y);
         if (got.last !== want.last) report("last", want.last, got.last);
      endfunction
   endclass

endpackage

FILE: tb/tb_segment_gap_bridger.sv
// Top-level testbench for the segment gap bridger: clock, reset, stimulus and result checks.
`timescale 1ns / 100ps

module tb_segment_gap_bridger;
   import sgb_pkg::*;
   import sgb_tb_pkg::*;

   localparam int MAX_SEGMENTS = 64;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 300;
   localparam int COORD_MAX = (1 << COORD_BITS) - 1;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   req_type               req_data = '0;
   logic                  busy;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  csr_write_en = 1'b0;
   logic [LIMIT_BITS-1:0] csr_write_data = '0;
   int                    idle_cycles = 0;

   bridge_tracker tracker = new(MAX_SEGMENTS);

   segment_gap_bridger #(
      .MAX_SEGMENTS(MAX_SEGMENTS)
   ) u_top (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_data      (req_data),
      .busy          (busy),
      .rsp_valid     (rsp_valid),
      .rsp_data      (rsp_data),
      .csr_write_en  (csr_write_en),
      .csr_write_data(csr_write_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         tracker.check_bridge(rsp_data);
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   function automatic int pick_gap(bit burst);
      int r;
      r = $urandom_range(0, 99);
      if (burst || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic coord_type near_coord(coord_type c, int spread);
      int v;
      v = int'(c) + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > COORD_MAX) v = COORD_MAX;
      return coord_type'(v);
   endfunction

   function automatic req_type random_segment(coord_type cx, coord_type cy, int spread,
                                              bit new_set);
      req_type r;
      if ($urandom_range(0, 4) == 0) begin
         r.start_x = coord_type'($urandom);
         r.start_y = coord_type'($urandom);
         r.end_x   = coord_type'($urandom);
         r.end_y   = coord_type'($urandom);
      end else begin
         r.start_x = near_coord(cx, spread);
         r.start_y = near_coord(cy, spread);
         r.end_x   = near_coord(cx, spread);
         r.end_y   = near_coord(cy, spread);
      end
      r.new_set = new_set;
      return r;
   endfunction

   // The beat is presented at the current edge and held until taken; a zero gap keeps
   // start high so the following beat is offered back to back.
   task automatic send_segment(req_type r, int gap_after);
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      tracker.note_segment(r);
      if (gap_after > 0) begin
         start <= 1'b0;
         repeat (gap_after) @(posedge clock);
      end
   endtask

   task automatic send_coords(int sx, int sy, int ex, int ey, bit new_set);
      req_type r;
      r.start_x = coord_type'(sx);
      r.start_y = coord_type'(sy);
      r.end_x   = coord_type'(ex);
      r.end_y   = coord_type'(ey);
      r.new_set = new_set;
      send_segment(r, pick_gap(1'b0));
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      do @(posedge clock); while (tracker.expected_bridges.size() != 0 || busy);
      repeat (MAX_SEGMENTS + 8) @(posedge clock);
   endtask

   task automatic write_limit(logic [LIMIT_BITS-1:0] value);
      wait_idle();
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      tracker.gap_limit = value;
   endtask

   task automatic run_directed();
      send_coords(0, 0, COORD_MAX, COORD_MAX, 1'b1);
      send_coords(0, 20, 2000, 2000, 1'b0);
      send_coords(3000, 100, 4095, 4070, 1'b0);
      send_coords(4090, 4095, 500, 3000, 1'b0);
      send_coords(10, 3000, 5, 5, 1'b0);
      send_coords(COORD_MAX, 0, 0, COORD_MAX, 1'b0);
      send_coords(0, 0, 0, 0, 1'b1);
      send_coords(0, 0, 0, 0, 1'b0);
      send_coords(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
      write_limit(16'd800);
      send_coords(100, 100, 4000, 100, 1'b1);
      send_coords(120, 120, 3000, 3000, 1'b0);
      send_coords(128, 100, 3000, 3000, 1'b0);
      write_limit(16'hFFFF);
      send_coords(1000, 1000, COORD_MAX, 0, 1'b1);
      send_coords(1200, 1100, 0, COORD_MAX, 1'b0);
      send_coords(1223, 1000, 0, COORD_MAX, 1'b0);
      write_limit(16'd50000);
      send_coords(2000, 2000, 100, 100, 1'b1);
      send_coords(2223, 2000, 50, 50, 1'b0);
      write_limit(16'd0);
      send_coords(5, 5, 5, 5, 1'b1);
      send_coords(5, 5, 5, 5, 0);
      write_limit(LIMIT_RESET);
   endtask

   task automatic run_random();
      int          sent;
      int          phase_len;
      int          spread;
      bit          burst;
      coord_type   cx;
      coord_type   cy;
      logic [LIMIT_BITS-1:0] limit_value;
      sent = 0;
      // Fill the table past capacity with mostly close segments so most comparisons bridge.
      write_limit(16'hFFFF);
      cx = coord_type'($urandom);
      cy = coord_type'($urandom);
      for (int i = 0; i < MAX_SEGMENTS + 6; i++) begin
         send_segment(random_segment(cx, cy, 20, i == 0), pick_gap(1'b0));
         sent++;
      end
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 7))
            0: limit_value = 16'd0;
            1: limit_value = 16'd1;
            2: limit_value = 16'd50000;
            3: limit_value = 16'hFFFF;
            4: limit_value = LIMIT_RESET;
            5: limit_value = LIMIT_BITS'($urandom_range(0, 65535));
            default: limit_value = LIMIT_BITS'($urandom_range(200, 20000));
         endcase
         write_limit(limit_value);
         case ($urandom_range(0, 2))
            0: spread = 8;
            1: spread = 40;
            default: spread = 150;
         endcase
         burst     = ($urandom_range(0, 3) == 0);
         phase_len = $urandom_range(4, 40);
         cx        = coord_type'($urandom);
         cy        = coord_type'($urandom);
         for (int i = 0; i < phase_len; i++) begin
            send_segment(random_segment(cx, cy, spread,
                                        (i == 0) ? bit'($urandom_range(0, 1))
                                                 : ($urandom_range(0, 15) == 0)),
                         pick_gap(burst));
            sent++;
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      run_random();
      wait_idle();
      if (tracker.mismatches == 0 && tracker.expected_bridges.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
